[hw/rtl/rle816_pkg.sv]
// shared constants, register indexes and the packer request type
// for the run-length encoder; no dependencies
package rle816_pkg;

  localparam int unsigned MaxBlock  = 128;
  localparam int unsigned IdxW      = $clog2(MaxBlock);
  localparam int unsigned FillW     = $clog2(MaxBlock + 1);
  localparam int unsigned SizeW     = FillW + 1;
  localparam int unsigned ElemW     = 16;
  localparam int unsigned WordBytes = 8;
  localparam int unsigned WordW     = 8 * WordBytes;
  localparam int unsigned CountW    = 4;
  localparam int unsigned LenW      = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [7:0] RepeatFlag = 8'h80;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_MODE      = 1'b0,
    REG_OUTPUT_CAPACITY = 1'b1
  } cfg_reg_e;

  // one byte or one end-of-item flush toward the word packer
  typedef struct packed {
    logic            push;
    logic            flush;
    logic [7:0]      data;
    logic            last;
    logic            failed;
    logic [LenW-1:0] len;
  } pk_req_t;

endpackage

[hw/rtl/rle816_if.sv]
// valid/ready channel interfaces for source elements and packed result words
// depends on rle816_pkg
interface rle816_in_if;
  import rle816_pkg::*;
  logic             valid;
  logic             ready;
  logic [ElemW-1:0] element;
  logic             end_of_stream;

  modport source (output valid, output element, output end_of_stream, input ready);
  modport sink (input valid, input element, input end_of_stream, output ready);
endinterface

interface rle816_out_if;
  import rle816_pkg::*;
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  packed_bytes;
  logic [CountW-1:0] byte_count;
  logic              final_word;
  logic              failed;
  logic [LenW-1:0]   encoded_length;

  modport source (output valid, output packed_bytes, output byte_count, output final_word,
                  output failed, output encoded_length, input ready);
  modport sink (input valid, input packed_bytes, input byte_count, input final_word,
                input failed, input encoded_length, output ready);
endinterface

[hw/rtl/run_length_encoder_8_16_core.sv]
// Run-length encoder in the PackBits style for byte or 16-bit pixel elements. Each transfer
// on the input carries one element; runs of 2..128 equal elements become a repeat block
// (0x80|(n-1), element) and other elements gather in a 128-entry literal store and leave as
// (n-1, elements). The bytes caused by one element are packed into 8-byte result words,
// first byte in bits 7:0; the last word of a stream has final_word set and reports the
// total length, or failed with length 0 once a block did not fit in output_capacity.
// Elements are handled one at a time: an item steps through the decide, tail and flush
// states, and each block it writes adds a reservation step and a control byte before the
// encoded element bytes (the emitter moves one byte per cycle while the packer is ready and
// reads the literal store through its single read port).
// Configuration registers: index 0 pixel_mode, index 1 output_capacity; the user is to have
// them written only when idle, and the block itself does not enforce this.
// depends on rle816_pkg, rle816_if, rle816_lit_mem and rle816_packer
module run_length_encoder_8_16_core import rle816_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  rle816_in_if.sink           in_i,
  rle816_out_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECIDE = 9'b000000010,
    S_TAIL   = 9'b000000100,
    S_TAIL2  = 9'b000001000,
    S_RSV    = 9'b000010000,
    S_CTRL   = 9'b000100000,
    S_LO     = 9'b001000000,
    S_HI     = 9'b010000000,
    S_FLUSH  = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  state_e           ret_q, ret_d;
  logic [ElemW-1:0] x_q, x_d;
  logic             eos_q, eos_d;
  logic [ElemW-1:0] held_q, held_d;
  logic [FillW-1:0] rep_q, rep_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [LenW-1:0]  bytes_q, bytes_d;
  logic             ovf_q, ovf_d;
  logic             kind_lit_q, kind_lit_d;
  logic             load_after_q, load_after_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             pixel_mode_q;
  logic [LenW-1:0]  cap_q;

  logic             mem_we;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic [ElemW-1:0] mem_rdata;
  pk_req_t          pk_req;
  logic             pk_ready;

  logic             emit_done;
  logic [ElemW-1:0] elem_out;
  logic [FillW-1:0] blk_n;
  logic [SizeW-1:0] blk_size;
  logic [LenW:0]    new_total;
  logic             last_idx;
  logic [6:0]       ctrl_cnt;

  assign elem_out  = kind_lit_q ? mem_rdata : held_q;
  assign blk_n     = kind_lit_q ? fill_q : FillW'(1);
  assign blk_size  = SizeW'(1) + (pixel_mode_q ? {blk_n, 1'b0} : {1'b0, blk_n});
  assign new_total = (LenW+1)'(bytes_q) + (LenW+1)'(blk_size);
  assign last_idx  = ((FillW'(idx_q) + FillW'(1)) == fill_q);
  assign ctrl_cnt  = kind_lit_q ? 7'(fill_q - FillW'(1)) : 7'(rep_q - FillW'(1));

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    x_d          = x_q;
    eos_d        = eos_q;
    held_d       = held_q;
    rep_d        = rep_q;
    fill_d       = fill_q;
    bytes_d      = bytes_q;
    ovf_d        = ovf_q;
    kind_lit_d   = kind_lit_q;
    load_after_d = load_after_q;
    idx_d        = idx_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    pk_req       = '0;
    emit_done    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d     = pixel_mode_q ? in_i.element : {8'h00, in_i.element[7:0]};
          eos_d   = in_i.end_of_stream;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (rep_q == '0) begin
          held_d  = x_q;
          rep_d   = FillW'(1);
          state_d = S_TAIL;
        end else if ((x_q == held_q) && (rep_q < FillW'(MaxBlock))) begin
          rep_d = rep_q + FillW'(1);
          // a run begins: whatever gathered before it leaves as a literal
          if ((rep_q == FillW'(1)) && (fill_q != '0)) begin
            kind_lit_d = 1'b1;
            ret_d      = S_TAIL;
            state_d    = S_RSV;
          end else begin
            state_d = S_TAIL;
          end
        end else if ((x_q == held_q) || (rep_q >= FillW'(2))) begin
          // run ends or hits its limit; the new element is held after the block
          kind_lit_d   = 1'b0;
          load_after_d = 1'b1;
          ret_d        = S_TAIL;
          state_d      = S_RSV;
        end else begin
          mem_we = 1'b1;
          fill_d = fill_q + FillW'(1);
          held_d = x_q;
          rep_d  = FillW'(1);
          if (fill_q == FillW'(MaxBlock - 1)) begin
            kind_lit_d = 1'b1;
            ret_d      = S_TAIL;
            state_d    = S_RSV;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (!eos_q) begin
          state_d = S_FLUSH;
        end else if (rep_q >= FillW'(2)) begin
          kind_lit_d = 1'b0;
          ret_d      = S_TAIL2;
          state_d    = S_RSV;
        end else if (rep_q == FillW'(1)) begin
          mem_we = 1'b1;
          fill_d = fill_q + FillW'(1);
          if (fill_q == FillW'(MaxBlock - 1)) begin
            kind_lit_d = 1'b1;
            ret_d      = S_TAIL2;
            state_d    = S_RSV;
          end else begin
            state_d = S_TAIL2;
          end
        end else begin
          state_d = S_TAIL2;
        end
      end
      S_TAIL2: begin
        if (fill_q != '0) begin
          kind_lit_d = 1'b1;
          ret_d      = S_FLUSH;
          state_d    = S_RSV;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_RSV: begin
        if (ovf_q) begin
          emit_done = 1'b1;
        end else if (new_total > (LenW+1)'(cap_q)) begin
          ovf_d     = 1'b1;
          emit_done = 1'b1;
        end else begin
          bytes_d = new_total[LenW-1:0];
          state_d = S_CTRL;
        end
      end
      S_CTRL: begin
        pk_req.push = 1'b1;
        pk_req.data = kind_lit_q ? {1'b0, ctrl_cnt} : (RepeatFlag | {1'b0, ctrl_cnt});
        if (pk_ready) begin
          idx_d     = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = S_LO;
        end
      end
      S_LO: begin
        pk_req.push = 1'b1;
        pk_req.data = elem_out[7:0];
        if (pk_ready) begin
          if (pixel_mode_q) begin
            state_d = S_HI;
          end else if (kind_lit_q && !last_idx) begin
            idx_d     = idx_q + IdxW'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_q + IdxW'(1);
          end else begin
            emit_done = 1'b1;
          end
        end
      end
      S_HI: begin
        pk_req.push = 1'b1;
        pk_req.data = elem_out[15:8];
        if (pk_ready) begin
          if (kind_lit_q && !last_idx) begin
            idx_d     = idx_q + IdxW'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_q + IdxW'(1);
            state_d   = S_LO;
          end else begin
            emit_done = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        pk_req.flush  = 1'b1;
        pk_req.last   = eos_q;
        pk_req.failed = ovf_q;
        pk_req.len    = ovf_q ? '0 : bytes_q;
        if (pk_ready) begin
          if (eos_q) begin
            fill_d  = '0;
            held_d  = '0;
            rep_d   = '0;
            bytes_d = '0;
            ovf_d   = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // block finished or skipped: a literal always empties the store
    if (emit_done) begin
      if (kind_lit_q) begin
        fill_d = '0;
      end
      if (load_after_q) begin
        held_d       = x_q;
        rep_d        = FillW'(1);
        load_after_d = 1'b0;
      end
      state_d = ret_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      eos_q        <= 1'b0;
      held_q       <= '0;
      rep_q        <= '0;
      fill_q       <= '0;
      bytes_q      <= '0;
      ovf_q        <= 1'b0;
      kind_lit_q   <= 1'b0;
      load_after_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      eos_q        <= eos_d;
      held_q       <= held_d;
      rep_q        <= rep_d;
      fill_q       <= fill_d;
      bytes_q      <= bytes_d;
      ovf_q        <= ovf_d;
      kind_lit_q   <= kind_lit_d;
      load_after_q <= load_after_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_mode_q <= 1'b0;
      cap_q        <= '1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PIXEL_MODE:      pixel_mode_q <= cfg_data_i[0];
        REG_OUTPUT_CAPACITY: cap_q        <= cfg_data_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  rle816_lit_mem u_lit_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[IdxW-1:0]),
    .wdata_i (held_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rle816_packer u_packer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (pk_req),
    .ready_o (pk_ready),
    .out_o   (out_o)
  );

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MaxBlock) && rep_q <= FillW'(MaxBlock))
    else $error("literal fill or run length out of range");

  // nothing held means nothing gathered either
  a_empty_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_q == '0) |-> (fill_q == '0))
    else $error("literal store filled while no element held");

  a_stream_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) && eos_q && pk_ready |=>
      (rep_q == '0) && (bytes_q == '0) && !ovf_q)
    else $error("stream state not cleared after final transfer");

endmodule

[hw/rtl/rle816_lit_mem.sv]
// literal store: single write port, single read port, registered read data
// depends on rle816_pkg
module rle816_lit_mem import rle816_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [ElemW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [ElemW-1:0] rdata_o
);

  logic [ElemW-1:0] mem_q [MaxBlock];
  logic [ElemW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rle816_packer.sv]
// packs the byte stream of one item into 8-byte words behind an output register
// depends on rle816_pkg and rle816_out_if
module rle816_packer import rle816_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pk_req_t req_i,
  output logic    ready_o,
  rle816_out_if.source out_o
);

  logic [WordW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_bytes_q, out_bytes_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;
  logic              out_last_q, out_last_d;
  logic              out_failed_q, out_failed_d;
  logic [LenW-1:0]   out_len_q, out_len_d;

  logic       out_free;
  logic       cnt_full;
  logic       fresh;
  logic [2:0] pos;

  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_full = (cnt_q == CountW'(WordBytes));
  assign fresh    = (cnt_q == '0) || cnt_full;
  assign pos      = fresh ? 3'd0 : cnt_q[2:0];

  always_comb begin
    if (req_i.flush) begin
      ready_o = ((cnt_q == '0) && !req_i.last) || out_free;
    end else begin
      ready_o = !cnt_full || out_free;
    end
  end

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_bytes_d  = out_bytes_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    out_failed_d = out_failed_q;
    out_len_d    = out_len_q;

    if (req_i.push && ready_o) begin
      if (cnt_full) begin
        out_valid_d  = 1'b1;
        out_bytes_d  = acc_q;
        out_cnt_d    = cnt_q;
        out_last_d   = 1'b0;
        out_failed_d = 1'b0;
        out_len_d    = '0;
      end
      for (int i = 0; i < WordBytes; i++) begin
        if (3'(i) == pos) begin
          acc_d[8*i +: 8] = req_i.data;
        end else if (fresh) begin
          acc_d[8*i +: 8] = 8'h00;
        end
      end
      cnt_d = CountW'(pos) + CountW'(1);
    end else if (req_i.flush && ready_o && ((cnt_q != '0) || req_i.last)) begin
      out_valid_d  = 1'b1;
      out_bytes_d  = (cnt_q == '0) ? '0 : acc_q;
      out_cnt_d    = cnt_q;
      out_last_d   = req_i.last;
      out_failed_d = req_i.last && req_i.failed;
      out_len_d    = req_i.last ? req_i.len : '0;
      cnt_d        = '0;
    end else if (req_i.flush && ready_o) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    out_bytes_q  <= out_bytes_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
    out_failed_q <= out_failed_d;
    out_len_q    <= out_len_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.packed_bytes   = out_bytes_q;
  assign out_o.byte_count     = out_cnt_q;
  assign out_o.final_word     = out_last_q;
  assign out_o.failed         = out_failed_q;
  assign out_o.encoded_length = out_len_q;

  // an empty word only ever closes a stream
  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q != '0) || out_last_q)
    else $error("empty result word without final flag");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(WordBytes))
    else $error("packer byte count out of range");

endmodule
